@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the shadow write filter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lsw_pkg.sv @@
// Package for the LCD shadow write filter: sizes, codes and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package lsw_pkg;

  localparam int CELLS     = 32;
  localparam int LINE2     = 16;
  localparam int CW        = $clog2(CELLS + 1);
  localparam int IW        = $clog2(CELLS);
  localparam int KIND_W    = 3;
  localparam int POS_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int CURSOR_W  = 6;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  localparam logic [CHAR_W-1:0] BLANK = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 3'd0,
    KIND_HOME  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_SETWR = 3'd3,
    KIND_SET   = 3'd4
  } kind_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_HOME  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_DATA  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic clr;
    logic home;
    logic set1;
    logic set2;
    logic wr;
  } plan_t;

  typedef struct packed {
    logic load;
    logic look;
    logic commit;
    logic emit;
    cmd_e code;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  out_ready;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsw_datapath.sv @@
// Datapath of the LCD shadow write filter: request registers, shadow
// memory, cursors and output register. Uses lsw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lsw_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  lsw_pkg::ctrl_cmd_t                  cmd_i,
  output lsw_pkg::ctrl_sts_t                  sts_o,
  input  wire [lsw_pkg::S_TDATA_W-1:0]        s_tdata_i,
  input  wire [lsw_pkg::KIND_W-1:0]           s_tuser_i,
  input  wire                                 m_tready_i,
  output logic                                m_tvalid_o,
  output logic [lsw_pkg::M_TDATA_W-1:0]       m_tdata_o,
  output logic [lsw_pkg::CMD_W-1:0]           m_tuser_o,
  output logic                                m_tlast_o
);

  localparam int CW = lsw_pkg::CW;
  localparam int IW = lsw_pkg::IW;

  logic [lsw_pkg::KIND_W-1:0] kind_q;
  logic [lsw_pkg::POS_W-1:0]  pos_q;
  logic [lsw_pkg::CHAR_W-1:0] ch_q;
  logic [CW-1:0]              t_q;
  logic [CW-1:0]              t_d;
  logic [CW-1:0]              lc_q, lc_d;
  logic [CW-1:0]              pc_q, pc_d;
  logic [lsw_pkg::CHAR_W-1:0] mem [lsw_pkg::CELLS];
  logic [lsw_pkg::CELLS-1:0]  vld_q;
  logic [lsw_pkg::CHAR_W-1:0] rd_q;
  logic                       rv_q;

  logic                       out_valid_q;
  logic [lsw_pkg::CHAR_W-1:0] arg_q, arg_d;
  logic [lsw_pkg::CURSOR_W-1:0] cur_q, cur_d;
  lsw_pkg::cmd_e              code_q;
  logic                       last_q;

  logic                       is_mv, is_wr, in_range, line2, adv;
  logic [lsw_pkg::CHAR_W-1:0] eff;
  logic [CW-1:0]              pos_sat, pc_after;
  lsw_pkg::plan_t             plan;

  assign is_mv = (kind_q == lsw_pkg::KIND_SETWR) || (kind_q == lsw_pkg::KIND_SET);
  assign is_wr = (kind_q == lsw_pkg::KIND_WRITE) || (kind_q == lsw_pkg::KIND_SETWR);

  always_comb begin
    if ({1'b0, pos_q} > (lsw_pkg::POS_W + 1)'(lsw_pkg::CELLS)) begin
      pos_sat = CW'(lsw_pkg::CELLS);
    end else begin
      pos_sat = CW'(pos_q);
    end
    t_d = is_mv ? pos_sat : lc_q;
  end

  assign eff      = rv_q ? rd_q : lsw_pkg::BLANK;
  assign in_range = t_q < CW'(lsw_pkg::CELLS);
  assign line2    = (int'(t_q) == lsw_pkg::LINE2);
  assign adv      = is_wr && in_range;

  always_comb begin
    plan.clr  = (kind_q == lsw_pkg::KIND_CLEAR);
    plan.home = (kind_q == lsw_pkg::KIND_HOME);
    plan.set1 = is_mv && ((t_q != pc_q) || line2);
    plan.wr   = adv && (eff != ch_q);
    pc_after  = plan.set1 ? t_q : pc_q;
    plan.set2 = plan.wr && ((pc_after != t_q) || line2);
  end

  always_comb begin
    lc_d = lc_q;
    pc_d = pc_q;
    if (plan.clr || plan.home) begin
      lc_d = '0;
      pc_d = '0;
    end else begin
      if (is_mv || is_wr) begin
        lc_d = t_q + CW'(adv);
      end
      if (plan.wr) begin
        pc_d = t_q + CW'(1);
      end else if (plan.set1) begin
        pc_d = t_q;
      end
    end
  end

  always_comb begin
    case (cmd_i.code)
      lsw_pkg::CMD_SET: begin
        arg_d = lsw_pkg::CHAR_W'(t_q);
        cur_d = lsw_pkg::CURSOR_W'(t_q);
      end
      lsw_pkg::CMD_DATA: begin
        arg_d = ch_q;
        cur_d = lsw_pkg::CURSOR_W'(t_q + CW'(1));
      end
      default: begin
        arg_d = '0;
        cur_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= s_tuser_i;
      pos_q  <= s_tdata_i[lsw_pkg::POS_W-1:0];
      ch_q   <= s_tdata_i[lsw_pkg::POS_W +: lsw_pkg::CHAR_W];
    end
    if (cmd_i.look) begin
      t_q <= t_d;
    end
    rd_q <= mem[IW'(t_d)];
    rv_q <= vld_q[IW'(t_d)];
    if (cmd_i.commit && plan.wr) begin
      mem[IW'(t_q)] <= ch_q;
    end
    if (cmd_i.emit) begin
      arg_q  <= arg_d;
      cur_q  <= cur_d;
      code_q <= cmd_i.code;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q        <= '0;
      pc_q        <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        lc_q <= lc_d;
        pc_q <= pc_d;
        if (plan.clr) begin
          vld_q <= '0;
        end else if (plan.wr) begin
          vld_q[IW'(t_q)] <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.plan      = plan;
  assign sts_o.out_ready = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(lsw_pkg::M_TDATA_W - lsw_pkg::CHAR_W - lsw_pkg::CURSOR_W)'(0),
                       cur_q, arg_q};
  assign m_tuser_o  = code_q;
  assign m_tlast_o  = last_q;

  `LSW_ASSERT_SAME(a_lc_range, clk_i, rst_ni, 1'b1, lc_q <= CW'(lsw_pkg::CELLS),
                   "logical cursor beyond end")
  `LSW_ASSERT_NEXT(a_wr_sync, clk_i, rst_ni, cmd_i.commit && plan.wr, pc_q == lc_q,
                   "panel cursor out of step after write")

endmodule

`default_nettype wire

@@ hw/rtl/lsw_ctrl.sv @@
// Controller of the LCD shadow write filter: sequences load, lookup,
// commit and command emission. Uses lsw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lsw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  input  lsw_pkg::ctrl_sts_t  sts_i,
  output lsw_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_PLAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  lsw_pkg::plan_t pend_q, pend_d, rest;
  lsw_pkg::cmd_e  code;

  always_comb begin
    rest = pend_q;
    if (pend_q.clr) begin
      code     = lsw_pkg::CMD_CLEAR;
      rest.clr = 1'b0;
    end else if (pend_q.home) begin
      code      = lsw_pkg::CMD_HOME;
      rest.home = 1'b0;
    end else if (pend_q.set1) begin
      code      = lsw_pkg::CMD_SET;
      rest.set1 = 1'b0;
    end else if (pend_q.set2) begin
      code      = lsw_pkg::CMD_SET;
      rest.set2 = 1'b0;
    end else begin
      code    = lsw_pkg::CMD_DATA;
      rest.wr = 1'b0;
    end
  end

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    s_tready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.code   = code;
    cmd_o.last   = (rest == '0);
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.commit = 1'b1;
        pend_d       = sts_i.plan;
        state_d      = (sts_i.plan != '0) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          pend_d     = rest;
          if (rest == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  `LSW_ASSERT_SAME(a_emit_ready, clk_i, rst_ni, cmd_o.emit, sts_i.out_ready,
                   "emit into a full output register")
  `LSW_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, cmd_o.emit && cmd_o.last, state_q == S_IDLE,
                   "controller busy after final command")

endmodule

`default_nettype wire

@@ hw/rtl/lcd_shadow_write_filter.sv @@
// An input request passes through capture, shadow lookup, and plan and
// state update, then emits each panel command it causes, zero to three,
// each command waiting for room in the single output register; the
// next request is accepted once the last command of the current one is in
// that register. Clear, home, write, set-cursor-then-write and set-cursor
// requests are filtered against a 32-cell shadow; unchanged-character
// writes and redundant cursor moves, bar to line 2, never reach the panel.
// Top level: instantiates lsw_ctrl and lsw_datapath; uses lsw_pkg.
`default_nettype none

module lcd_shadow_write_filter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [5:0] position, [13:6] char_code, [15:14] zero
  input  wire [lsw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] kind
  input  wire [lsw_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [7:0] argument, [13:8] cursor, [15:14] zero
  output logic [lsw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] command
  output logic [lsw_pkg::CMD_W-1:0]        m_axis_tuser,
  output logic                             m_axis_tlast
);

  lsw_pkg::ctrl_cmd_t cmd;
  lsw_pkg::ctrl_sts_t sts;

  lsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsw_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
